FILE: rtl/vq_index_flag_word_packer_top_assert.svh
// Assertion macros for the VQ index word packer.
// Included by the top level; relies on clk and rst_n in the including scope.
`ifndef VQ_INDEX_FLAG_WORD_PACKER_TOP_ASSERT_SVH
`define VQ_INDEX_FLAG_WORD_PACKER_TOP_ASSERT_SVH

// Same-cycle implication, masked while reset is held.
`define VQPK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is held.
`define VQPK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/vqpk_pkg.sv
// Shared types and constants for the VQ index word packer.
// No dependencies; used by vqpk_payload_ram and the top level.
package vqpk_pkg;

  localparam int FLAG_WORD_BITS = 32;
  localparam int PAYLOAD_DEPTH  = 32;
  localparam int PTR_W          = $clog2(PAYLOAD_DEPTH);
  localparam int CNT_W          = $clog2(PAYLOAD_DEPTH + 1);
  localparam int FIDX_W         = $clog2(FLAG_WORD_BITS);
  localparam int ADDR_W         = 3;

  // pack_mode codes (value 3 behaves as single-vector)
  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_MIXED  = 2'd1;
  localparam logic [1:0] MODE_MOTION = 2'd2;

  // block_coding codes (value 3 behaves as single vector)
  localparam logic [1:0] CODING_SINGLE = 2'd0;
  localparam logic [1:0] CODING_QUAD   = 2'd1;
  localparam logic [1:0] CODING_SKIP   = 2'd2;

  // register select: word address bit of paddr
  localparam logic REG_PACK_MODE = 1'b0;

  localparam logic [2:0] BYTES_FLAG   = 3'd4;
  localparam logic [2:0] BYTES_SINGLE = 3'd1;
  localparam logic [2:0] BYTES_QUAD   = 3'd4;

  typedef struct packed {
    logic [1:0] block_coding;
    logic [7:0] single_index;
    logic [7:0] quad_index_0;
    logic [7:0] quad_index_1;
    logic [7:0] quad_index_2;
    logic [7:0] quad_index_3;
    logic       strip_end;
  } in_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic [2:0]  out_bytes;
    logic        is_flag_word;
    logic        strip_done;
  } out_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  len;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] addr;
    entry_t           data;
  } ram_wr_t;

  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] addr;
  } ram_rd_t;

endpackage

FILE: rtl/vqpk_payload_ram.sv
// Payload queue storage: one write port, one read port, registered read data.
// Depends on vqpk_pkg for the entry and port types.
module vqpk_payload_ram (
  input  logic              clk,
  input  vqpk_pkg::ram_wr_t wr,
  input  vqpk_pkg::ram_rd_t rd,
  output vqpk_pkg::entry_t  rdata
);

  vqpk_pkg::entry_t mem [vqpk_pkg::PAYLOAD_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    // hold read data until the next read
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

FILE: rtl/vq_index_flag_word_packer_top.sv
// Top level of the VQ index word packer: control, flag word assembly, output beat.
// Depends on vqpk_pkg, vqpk_payload_ram and vq_index_flag_word_packer_top_assert.svh.
//
// Packs one coded 4x4 block per input beat into the strip's index stream.
// In single-vector mode each block gives one result (its index byte). In mixed
// and motion modes a block that completes no flag word is absorbed while the
// packer stays idle: its flag bits go into the flag register and its payload
// into a 32-entry payload queue held in a synchronous memory. A block that
// completes a word (or ends the strip) is accepted, then emits its results one
// by one, with a memory read ahead of each burst of queued payloads: at most
// two flag words and two bursts, up to 33 results. The single read port of the
// payload memory and the one-beat output register pace the results; output
// stall holds them back. While results drain, in_stall stays high. The output
// register holds a finished beat, so the last result may still wait while the
// next block is already accepted. Writing pack_mode drops the partial strip;
// the user must write it only while idle, as the block does not enforce this.
// No clearing pass follows reset: only queued entries are ever read.
module vq_index_flag_word_packer_top (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  vqpk_pkg::in_t                in_data,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output vqpk_pkg::out_t               out_data,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vqpk_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int PTR_W  = vqpk_pkg::PTR_W;
  localparam int CNT_W  = vqpk_pkg::CNT_W;
  localparam int FIDX_W = vqpk_pkg::FIDX_W;
  localparam int FW     = vqpk_pkg::FLAG_WORD_BITS;
  localparam logic [FW-1:0] FLAG_MSB = {1'b1, {(FW-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_WORD1,
    S_DRAIN1,
    S_WORD2,
    S_DRAIN2
  } state_t;

  // wrap a queue position back into the memory's address range
  function automatic logic [PTR_W-1:0] ptr_wrap(input logic [CNT_W:0] sum);
    logic [CNT_W:0] depth;
    depth = (CNT_W+1)'(vqpk_pkg::PAYLOAD_DEPTH);
    if (sum >= depth) begin
      return PTR_W'(sum - depth);
    end
    return PTR_W'(sum);
  endfunction

  state_t              state_r;
  logic [1:0]          mode_r;
  logic [FW-1:0]       accum_r;
  logic [FIDX_W-1:0]   cnt_r;
  logic [CNT_W-1:0]    qcount_r;
  logic [PTR_W-1:0]    head_r;
  logic                out_valid_r;
  vqpk_pkg::out_t      out_r;
  logic                pend_r;
  logic [CNT_W-1:0]    rd_left_r;
  logic [CNT_W-1:0]    ld_left_r;
  // emission plan of the block in flight
  logic [FW-1:0]       w1_word_r;
  logic                w1_flag_r;
  logic [CNT_W-1:0]    n1_r;
  logic                w2v_r;
  logic [FW-1:0]       w2_word_r;
  logic [CNT_W-1:0]    n2_r;
  logic                end_r;

  // next-state values computed from the accepted block
  logic [FW-1:0]       accum_nxt;
  logic [FIDX_W-1:0]   cnt_nxt;
  logic [CNT_W-1:0]    qcount_nxt;
  logic                w1v_nxt;
  logic [FW-1:0]       w1_word_nxt;
  logic                w1_flag_nxt;
  logic [CNT_W-1:0]    n1_nxt;
  logic                w2v_nxt;
  logic [FW-1:0]       w2_word_nxt;
  logic [CNT_W-1:0]    n2_nxt;

  logic                in_accept;
  logic                cfg_wr;
  logic                coded;
  logic                is_quad;
  logic                last_bit;
  logic                two_bits;
  logic                full;
  logic                push;
  logic                has_room;
  logic [FW-1:0]       bit_a;
  logic [FW-1:0]       acc_a;
  logic [FW-1:0]       acc_b;
  logic [FW-1:0]       single_word;
  logic [FIDX_W-1:0]   cnt_after;
  logic [CNT_W-1:0]    q_after;
  logic [CNT_W-1:0]    q_plus;
  vqpk_pkg::entry_t    pentry;

  logic                out_free;
  logic                drain_st;
  logic                load;
  logic                last_load;
  logic                no_drain;
  vqpk_pkg::ram_wr_t   ram_wr;
  vqpk_pkg::ram_rd_t   ram_rd;
  vqpk_pkg::entry_t    ram_rdata;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == vqpk_pkg::REG_PACK_MODE) ? 32'(mode_r) : 32'd0;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  // a held final beat may sit while the next block waits in S_WORD1
  assign no_drain  = ((state_r == S_IDLE) || (state_r == S_WORD1)) && !pend_r;

  // ---------------------------------------------------------------------------
  // Plan for one block: flag register update, queue push, and what to emit.
  // Emission is at most: word 1, n1 queued payloads, word 2, n2 payloads.
  // ---------------------------------------------------------------------------
  always_comb begin
    coded       = (in_data.block_coding != vqpk_pkg::CODING_SKIP);
    is_quad     = (in_data.block_coding == vqpk_pkg::CODING_QUAD);
    single_word = {in_data.single_index, 24'd0};
    pentry.word = is_quad ? {in_data.quad_index_0, in_data.quad_index_1,
                             in_data.quad_index_2, in_data.quad_index_3}
                          : single_word;
    pentry.len  = is_quad ? vqpk_pkg::BYTES_QUAD : vqpk_pkg::BYTES_SINGLE;
    has_room    = (qcount_r != CNT_W'(vqpk_pkg::PAYLOAD_DEPTH));
    last_bit    = (cnt_r == FIDX_W'(FW - 1));
    bit_a       = FLAG_MSB >> cnt_r;
    two_bits    = 1'b0;
    full        = 1'b0;
    acc_a       = '0;
    acc_b       = '0;
    cnt_after   = '0;
    q_after     = '0;
    q_plus      = '0;
    push        = 1'b0;

    accum_nxt   = accum_r;
    cnt_nxt     = cnt_r;
    qcount_nxt  = qcount_r;
    w1v_nxt     = 1'b0;
    w1_word_nxt = single_word;
    w1_flag_nxt = 1'b1;
    n1_nxt      = '0;
    w2v_nxt     = 1'b0;
    w2_word_nxt = '0;
    n2_nxt      = '0;

    case (mode_r)
      vqpk_pkg::MODE_MIXED: begin
        push   = has_room;
        q_plus = qcount_r + CNT_W'(push);
        acc_a  = accum_r | (is_quad ? bit_a : '0);
        full   = last_bit || in_data.strip_end;
        w1v_nxt     = full;
        w1_word_nxt = acc_a;
        n1_nxt      = q_plus;
        accum_nxt   = full ? '0 : acc_a;
        cnt_nxt     = full ? '0 : cnt_r + FIDX_W'(1);
        qcount_nxt  = full ? '0 : q_plus;
      end
      vqpk_pkg::MODE_MOTION: begin
        // coded bit, then the four-vector bit if it still fits
        push     = coded && has_room;
        q_plus   = qcount_r + CNT_W'(push);
        two_bits = coded && !last_bit;
        acc_a    = accum_r | (coded ? bit_a : '0);
        acc_b    = acc_a | ((two_bits && is_quad) ? (bit_a >> 1) : '0);
        full     = last_bit || (two_bits && cnt_r == FIDX_W'(FW - 2));
        if (full) begin
          w1v_nxt     = 1'b1;
          w1_word_nxt = acc_b;
          // a block whose bits both fit follows its own flag word
          n1_nxt      = two_bits ? q_plus : qcount_r;
          // carried second bit opens the next word; its payload waits
          q_after     = (coded && last_bit) ? CNT_W'(push) : '0;
          accum_nxt   = (coded && last_bit && is_quad) ? FLAG_MSB : '0;
          cnt_after   = (coded && last_bit) ? FIDX_W'(1) : '0;
        end else begin
          q_after     = q_plus;
          accum_nxt   = acc_b;
          cnt_after   = cnt_r + FIDX_W'(1) + FIDX_W'(two_bits);
        end
        cnt_nxt    = cnt_after;
        qcount_nxt = q_after;
        if (in_data.strip_end && cnt_after != '0) begin
          if (full) begin
            w2v_nxt     = 1'b1;
            w2_word_nxt = accum_nxt;
            n2_nxt      = q_after;
          end else begin
            w1v_nxt     = 1'b1;
            w1_word_nxt = accum_nxt;
            n1_nxt      = q_after;
          end
        end
      end
      default: begin
        w1v_nxt     = 1'b1;
        w1_word_nxt = single_word;
        w1_flag_nxt = 1'b0;
      end
    endcase

    // strip end flushes everything
    if (in_data.strip_end) begin
      accum_nxt  = '0;
      cnt_nxt    = '0;
      qcount_nxt = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Payload memory. Pushes happen only in the accept cycle and reads only
  // while draining, so the same entry is never read and written together.
  // ---------------------------------------------------------------------------
  always_comb begin
    out_free  = !out_valid_r || !out_stall;
    drain_st  = (state_r == S_DRAIN1) || (state_r == S_DRAIN2);
    load      = drain_st && pend_r && out_free;
    last_load = load && (ld_left_r == CNT_W'(1));

    ram_wr.en   = in_accept && push;
    ram_wr.addr = ptr_wrap((CNT_W+1)'(head_r) + (CNT_W+1)'(qcount_r));
    ram_wr.data = pentry;

    // issue a read when the read data slot is empty next cycle
    ram_rd.en   = drain_st && (rd_left_r != '0) && (!pend_r || load);
    ram_rd.addr = head_r;
  end

  vqpk_payload_ram u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .rd    (ram_rd),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Sequencer, strip state and output beat register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= vqpk_pkg::MODE_SINGLE;
      accum_r     <= '0;
      cnt_r       <= '0;
      qcount_r    <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      rd_left_r   <= '0;
      ld_left_r   <= '0;
    end else begin
      // drop the beat once taken; a load below overrides
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_wr && paddr[2] == vqpk_pkg::REG_PACK_MODE) begin
        mode_r   <= pwdata[1:0];
        accum_r  <= '0;
        cnt_r    <= '0;
        qcount_r <= '0;
      end

      // read pointer and outstanding read data
      if (ram_rd.en) begin
        head_r    <= ptr_wrap((CNT_W+1)'(head_r) + (CNT_W+1)'(1));
        rd_left_r <= rd_left_r - CNT_W'(1);
        pend_r    <= 1'b1;
      end else if (load) begin
        pend_r    <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            accum_r   <= accum_nxt;
            cnt_r     <= cnt_nxt;
            qcount_r  <= qcount_nxt;
            w1_word_r <= w1_word_nxt;
            w1_flag_r <= w1_flag_nxt;
            n1_r      <= n1_nxt;
            w2v_r     <= w2v_nxt;
            w2_word_r <= w2_word_nxt;
            n2_r      <= n2_nxt;
            end_r     <= in_data.strip_end;
            if (w1v_nxt) begin
              state_r <= S_WORD1;
            end
          end
        end
        S_WORD1: begin
          if (out_free) begin
            out_valid_r        <= 1'b1;
            out_r.out_word     <= w1_word_r;
            out_r.out_bytes    <= w1_flag_r ? vqpk_pkg::BYTES_FLAG : vqpk_pkg::BYTES_SINGLE;
            out_r.is_flag_word <= w1_flag_r;
            out_r.strip_done   <= end_r && (n1_r == '0) && !w2v_r;
            if (n1_r != '0) begin
              rd_left_r <= n1_r;
              ld_left_r <= n1_r;
              state_r   <= S_DRAIN1;
            end else if (w2v_r) begin
              state_r <= S_WORD2;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_WORD2: begin
          if (out_free) begin
            out_valid_r        <= 1'b1;
            out_r.out_word     <= w2_word_r;
            out_r.out_bytes    <= vqpk_pkg::BYTES_FLAG;
            out_r.is_flag_word <= 1'b1;
            out_r.strip_done   <= end_r && (n2_r == '0);
            if (n2_r != '0) begin
              rd_left_r <= n2_r;
              ld_left_r <= n2_r;
              state_r   <= S_DRAIN2;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_DRAIN1, S_DRAIN2: begin
          if (load) begin
            out_valid_r        <= 1'b1;
            out_r.out_word     <= ram_rdata.word;
            out_r.out_bytes    <= ram_rdata.len;
            out_r.is_flag_word <= 1'b0;
            out_r.strip_done   <= end_r && last_load &&
                                  ((state_r == S_DRAIN2) || !w2v_r);
            ld_left_r          <= ld_left_r - CNT_W'(1);
            if (last_load) begin
              state_r <= (state_r == S_DRAIN1 && w2v_r) ? S_WORD2 : S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`include "vq_index_flag_word_packer_top_assert.svh"

  `VQPK_ASSERT_NEXT(a_end_clears, in_accept && in_data.strip_end, cnt_r == '0 && qcount_r == '0 && accum_r == '0, "strip end left partial state")
  `VQPK_ASSERT_NOW(a_done_idle, out_valid_r && out_r.strip_done, no_drain, "strip done beat while results remain")
  `VQPK_ASSERT_NOW(a_queue_bound, 1'b1, qcount_r <= CNT_W'(vqpk_pkg::PAYLOAD_DEPTH), "payload queue count beyond depth")

endmodule

FILE: tb/index_stream_checker.sv
`timescale 1ns / 100ps
// Watches the packer's input, result and configuration ports, predicts the index stream
// and compares every result beat. Depends on vqpk_pkg.
module index_stream_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  vqpk_pkg::in_t                in_data,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  vqpk_pkg::out_t               out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vqpk_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  input  logic                         pready,
  output int                           fail_count,
  output int                           pending
);

  logic [1:0]        cur_mode;
  logic [31:0]       flag_acc;
  int                flag_fill;
  vqpk_pkg::entry_t  payload_queue[$];
  vqpk_pkg::out_t    step_words[$];
  vqpk_pkg::out_t    expected_words[$];
  vqpk_pkg::out_t    want;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic clear_strip();
    flag_acc  = '0;
    flag_fill = 0;
    payload_queue.delete();
  endtask

  task automatic add_flag_bit(input logic bit_val);
    flag_acc[vqpk_pkg::FLAG_WORD_BITS-1-flag_fill] = bit_val;
    flag_fill++;
  endtask

  task automatic push_word(input logic [31:0] word, input logic [2:0] nbytes,
                           input logic is_flag);
    vqpk_pkg::out_t w;
    w.out_word     = word;
    w.out_bytes    = nbytes;
    w.is_flag_word = is_flag;
    w.strip_done   = 1'b0;
    step_words.push_back(w);
  endtask

  // Send the flag word and start a fresh one.
  task automatic emit_flag_word();
    push_word(flag_acc, vqpk_pkg::BYTES_FLAG, 1'b1);
    flag_acc  = '0;
    flag_fill = 0;
  endtask

  task automatic flush_payloads();
    foreach (payload_queue[i]) push_word(payload_queue[i].word, payload_queue[i].len, 1'b0);
    payload_queue.delete();
  endtask

  task automatic queue_payload(input logic [31:0] word, input logic [2:0] len);
    vqpk_pkg::entry_t e;
    e.word = word;
    e.len  = len;
    if (payload_queue.size() < vqpk_pkg::PAYLOAD_DEPTH) payload_queue.push_back(e);
  endtask

  task automatic pack_block(input vqpk_pkg::in_t blk);
    logic           is_quad;
    logic           coded;
    logic           carry;
    logic           send_after;
    logic [31:0]    payload;
    logic [2:0]     payload_len;
    vqpk_pkg::out_t w;
    step_words.delete();
    is_quad     = (blk.block_coding == vqpk_pkg::CODING_QUAD);
    coded       = (blk.block_coding != vqpk_pkg::CODING_SKIP);
    carry       = 1'b0;
    send_after  = 1'b0;
    payload     = is_quad ? {blk.quad_index_0, blk.quad_index_1, blk.quad_index_2,
                             blk.quad_index_3}
                          : {blk.single_index, 24'h0};
    payload_len = is_quad ? vqpk_pkg::BYTES_QUAD : vqpk_pkg::BYTES_SINGLE;
    case (cur_mode)
      vqpk_pkg::MODE_MIXED: begin
        add_flag_bit(is_quad);
        queue_payload(payload, payload_len);
        if (flag_fill >= vqpk_pkg::FLAG_WORD_BITS || blk.strip_end) begin
          emit_flag_word();
          flush_payloads();
        end
      end
      vqpk_pkg::MODE_MOTION: begin
        add_flag_bit(coded);
        if (coded) begin
          if (flag_fill < vqpk_pkg::FLAG_WORD_BITS) add_flag_bit(is_quad);
          else carry = 1'b1;
        end
        if (flag_fill >= vqpk_pkg::FLAG_WORD_BITS) begin
          emit_flag_word();
          if (!coded || carry) flush_payloads();
          else send_after = 1'b1;
        end
        // the four-vector bit that did not fit opens the next word
        if (carry) begin
          flag_acc  = {is_quad, 31'h0};
          flag_fill = 1;
        end
        if (coded) queue_payload(payload, payload_len);
        if (send_after) flush_payloads();
        if (blk.strip_end && flag_fill > 0) begin
          emit_flag_word();
          flush_payloads();
        end
      end
      default: push_word({blk.single_index, 24'h0}, vqpk_pkg::BYTES_SINGLE, 1'b0);
    endcase
    if (blk.strip_end) clear_strip();
    foreach (step_words[i]) begin
      w = step_words[i];
      if (blk.strip_end && i == step_words.size() - 1) w.strip_done = 1'b1;
      expected_words.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_mode = vqpk_pkg::MODE_SINGLE;
      clear_strip();
      expected_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result beat: out_word %h", out_data.out_word);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (out_data.out_word !== want.out_word) begin
            $error("out_word: expected %h, got %h", want.out_word, out_data.out_word);
            fail_count++;
          end
          if (out_data.out_bytes !== want.out_bytes) begin
            $error("out_bytes: expected %0d, got %0d", want.out_bytes, out_data.out_bytes);
            fail_count++;
          end
          if (out_data.is_flag_word !== want.is_flag_word) begin
            $error("is_flag_word: expected %b, got %b", want.is_flag_word,
                   out_data.is_flag_word);
            fail_count++;
          end
          if (out_data.strip_done !== want.strip_done) begin
            $error("strip_done: expected %b, got %b", want.strip_done, out_data.strip_done);
            fail_count++;
          end
        end
      end
      if (psel && penable && pwrite && pready &&
          paddr[vqpk_pkg::ADDR_W-1] == vqpk_pkg::REG_PACK_MODE) begin
        cur_mode = pwdata[1:0];
        clear_strip();
      end
      if (in_valid && !in_stall) pack_block(in_data);
    end
    pending = expected_words.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Top of the packer testbench: clock, reset, block stimulus, result stall and verdict.
// Depends on vqpk_pkg, vq_index_flag_word_packer_top and index_stream_checker.
module testbench;

  // Codes with no name in the package; both fall back to single-vector behavior.
  localparam logic [1:0] CODING_OTHER  = 2'd3;
  localparam logic [1:0] MODE_OTHER    = 2'd3;
  localparam int         RANDOM_ITEMS  = 380;
  // Cycles to let the block settle once no result is pending: an absorbed block
  // may still be in flight, and one block can emit up to 33 beats and wait on reads.
  localparam int         SETTLE_CYCLES = 40;
  // Cycles without any accepted beat before the run is declared hung.
  localparam int         HANG_LIMIT    = 2000;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  vqpk_pkg::in_t               in_data;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  vqpk_pkg::out_t              out_data;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [vqpk_pkg::ADDR_W-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  int fail_count;
  int pending;
  bit calm = 1'b0;
  int run_left = 0;

  always #1 clk = ~clk;

  vq_index_flag_word_packer_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  index_stream_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Mostly no pause, often a short one, now and then a long one.
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 10);
    else return $urandom_range(20, 60);
  endfunction

  // Bias indices toward the two extremes so every bit sees both values early.
  function automatic logic [7:0] pick_index();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'h00;
    else if (r < 16) return 8'hff;
    else return 8'($urandom_range(0, 255));
  endfunction

  function automatic vqpk_pkg::in_t fixed_block(input logic [1:0] coding,
                                                input logic [7:0] single,
                                                input logic [31:0] quad, input logic last);
    vqpk_pkg::in_t blk;
    blk.block_coding = coding;
    blk.single_index = single;
    {blk.quad_index_0, blk.quad_index_1, blk.quad_index_2, blk.quad_index_3} = quad;
    blk.strip_end    = last;
    return blk;
  endfunction

  // Motion mode leans on skips to reach odd flag fills and the carried bit;
  // the other modes still see skip and the unnamed code as noise.
  function automatic vqpk_pkg::in_t random_block(input logic [1:0] cur_mode,
                                                 input logic last);
    logic [1:0] coding;
    int         r;
    r = $urandom_range(0, 99);
    if (cur_mode == vqpk_pkg::MODE_MOTION)
      coding = r < 40 ? vqpk_pkg::CODING_SKIP :
               r < 70 ? vqpk_pkg::CODING_QUAD :
               r < 95 ? vqpk_pkg::CODING_SINGLE : CODING_OTHER;
    else
      coding = r < 45 ? vqpk_pkg::CODING_SINGLE :
               r < 90 ? vqpk_pkg::CODING_QUAD :
               r < 95 ? vqpk_pkg::CODING_SKIP : CODING_OTHER;
    return fixed_block(coding, pick_index(),
                       {pick_index(), pick_index(), pick_index(), pick_index()}, last);
  endfunction

  function automatic logic [1:0] pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return vqpk_pkg::MODE_MOTION;
    else if (r < 70) return vqpk_pkg::MODE_MIXED;
    else if (r < 88) return vqpk_pkg::MODE_SINGLE;
    else return MODE_OTHER;
  endfunction

  // Present one block and hold it until the packer takes the beat.
  // Leave valid high afterwards so back-to-back blocks need no extra edge.
  task automatic send_block(input vqpk_pkg::in_t blk);
    int gap;
    gap = calm ? 0 : pick_pause();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_data  <= blk;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and hold until every predicted beat has come out.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
  endtask

  // Write pack_mode only once the packer is idle; upper data bits are junk on purpose.
  task automatic write_pack_mode(input logic [1:0] value);
    logic [31:0] word;
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    word      = $urandom();
    word[1:0] = value;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {vqpk_pkg::REG_PACK_MODE, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result-side stall: alternate flowing and stalled runs of random length.
  // Hold stall low entirely while a calm phase runs.
  always @(negedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
      run_left  <= 0;
    end else if (run_left > 0) begin
      run_left <= run_left - 1;
    end else begin
      out_stall <= !out_stall;
      run_left  <= out_stall ? $urandom_range(0, 12) : pick_pause();
    end
  end

  // Watchdog: end the run if no beat moves on any port for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin : stimulus
    int         random_count;
    int         phase;
    int         strips;
    int         strip_len;
    logic [1:0] phase_mode;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Single-vector mode out of reset: index extremes, every coding, strip end.
    send_block(fixed_block(vqpk_pkg::CODING_SINGLE, 8'h00, 32'h0000_0000, 1'b0));
    send_block(fixed_block(vqpk_pkg::CODING_SINGLE, 8'hff, 32'h0000_0000, 1'b0));
    send_block(fixed_block(vqpk_pkg::CODING_QUAD,   8'h5a, 32'hffff_ffff, 1'b0));
    send_block(fixed_block(vqpk_pkg::CODING_SKIP,   8'ha5, 32'h0000_0000, 1'b0));
    send_block(fixed_block(CODING_OTHER,            8'h0f, 32'h1234_5678, 1'b1));

    // Mode code 3 must behave as single-vector only.
    write_pack_mode(MODE_OTHER);
    send_block(fixed_block(vqpk_pkg::CODING_QUAD, 8'hc3, 32'hdead_beef, 1'b0));
    send_block(fixed_block(vqpk_pkg::CODING_SKIP, 8'h3c, 32'h0000_0000, 1'b1));

    // Mixed mode: skip and code 3 fall back to single vector.
    write_pack_mode(vqpk_pkg::MODE_MIXED);
    send_block(fixed_block(vqpk_pkg::CODING_QUAD,   8'h00, 32'h0000_0000, 1'b0));
    send_block(fixed_block(vqpk_pkg::CODING_SINGLE, 8'hff, 32'h0000_0000, 1'b0));
    send_block(fixed_block(vqpk_pkg::CODING_SKIP,   8'h81, 32'h0000_0000, 1'b0));
    send_block(fixed_block(CODING_OTHER,            8'h7e, 32'h0000_0000, 1'b0));
    send_block(fixed_block(vqpk_pkg::CODING_QUAD,   8'h00, 32'hffff_ffff, 1'b1));
    // Leave a partial strip behind; the next mode write must drop it.
    send_block(fixed_block(vqpk_pkg::CODING_QUAD,   8'h11, 32'h1234_5678, 1'b0));
    send_block(fixed_block(vqpk_pkg::CODING_SINGLE, 8'h80, 32'h0000_0000, 1'b0));

    // Motion mode: skips, both coded kinds, code 3, one-block strips.
    write_pack_mode(vqpk_pkg::MODE_MOTION);
    send_block(fixed_block(vqpk_pkg::CODING_SKIP,   8'h00, 32'h0000_0000, 1'b0));
    send_block(fixed_block(vqpk_pkg::CODING_SINGLE, 8'hff, 32'h0000_0000, 1'b0));
    send_block(fixed_block(vqpk_pkg::CODING_QUAD,   8'h00, 32'hffff_ffff, 1'b0));
    send_block(fixed_block(CODING_OTHER,            8'h42, 32'h0000_0000, 1'b0));
    send_block(fixed_block(vqpk_pkg::CODING_SKIP,   8'h99, 32'h0000_0000, 1'b0));
    send_block(fixed_block(vqpk_pkg::CODING_QUAD,   8'h00, 32'h0000_0000, 1'b1));
    send_block(fixed_block(vqpk_pkg::CODING_SKIP,   8'h24, 32'h0000_0000, 1'b1));
    send_block(fixed_block(vqpk_pkg::CODING_QUAD,   8'h00, 32'ha5a5_a5a5, 1'b1));

    write_pack_mode(vqpk_pkg::MODE_SINGLE);
    send_block(fixed_block(vqpk_pkg::CODING_SINGLE, 8'h3c, 32'h0000_0000, 1'b1));

    // Random phases: one mode per phase, a few full strips each, long enough
    // in the flag modes to fill whole words and hit the carried bit.
    // Trim the last strip so the random total lands on the item budget.
    random_count = 0;
    phase        = 0;
    while (random_count < RANDOM_ITEMS) begin
      phase_mode = pick_mode();
      write_pack_mode(phase_mode);
      calm   = (phase % 3 == 2);
      strips = $urandom_range(1, 3);
      for (int s = 0; s < strips && random_count < RANDOM_ITEMS; s++) begin
        if (phase_mode == vqpk_pkg::MODE_MIXED || phase_mode == vqpk_pkg::MODE_MOTION)
          strip_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8)
                                                  : $urandom_range(20, 70);
        else
          strip_len = $urandom_range(1, 12);
        if (strip_len > RANDOM_ITEMS - random_count) strip_len = RANDOM_ITEMS - random_count;
        for (int k = 0; k < strip_len; k++)
          send_block(random_block(phase_mode, k == strip_len - 1));
        random_count += strip_len;
        // Once in the run, stop sending until the packer has caught up.
        if (phase == 1 && s == 0) drain_results();
      end
      // Sometimes trail off mid-strip; the next mode write drops the rest.
      if (random_count < RANDOM_ITEMS && $urandom_range(0, 3) == 0) begin
        strip_len = $urandom_range(1, 20);
        if (strip_len > RANDOM_ITEMS - random_count) strip_len = RANDOM_ITEMS - random_count;
        for (int k = 0; k < strip_len; k++) send_block(random_block(phase_mode, 1'b0));
        random_count += strip_len;
      end
      phase++;
    end
    calm = 1'b0;

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

FILE: vq_index_flag_word_packer_top.f
+incdir+rtl
rtl/vqpk_pkg.sv
rtl/vqpk_payload_ram.sv
rtl/vq_index_flag_word_packer_top.sv
tb/index_stream_checker.sv
tb/testbench.sv
